>>> hw/rtl/pan_tilt_aim_angles_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pan/tilt aim unit
// Helpers for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PAN_TILT_AIM_ANGLES_UNIT_ASSERT_SVH
`define PAN_TILT_AIM_ANGLES_UNIT_ASSERT_SVH

// same-cycle implication
`define PTAA_ASSERT_IMPLY(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("ptaa assertion failed");

// next-cycle implication
`define PTAA_ASSERT_NEXT(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("ptaa assertion failed");

`endif

>>> hw/rtl/ptaa_pkg.sv
// ----------------------------------------------------------------------------
// ptaa_pkg
// Types, widths and the arctangent table of the pan/tilt aim unit.
// ----------------------------------------------------------------------------
package ptaa_pkg;

   localparam int COORD_BITS  = 16;
   localparam int ANGLE_STEPS = 16;
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int GUARD_SHIFT = 24;
   localparam int DATA_BITS   = DIFF_BITS + GUARD_SHIFT + 5;
   localparam int ANGLE_BITS  = 34;
   localparam int STEP_BITS   = 5;
   localparam int GAIN_BITS   = 18;
   localparam logic signed [GAIN_BITS-1:0] GAIN_Q16 = 18'sd107922;

   typedef struct packed {
      logic signed [DATA_BITS-1:0]  x;
      logic signed [DATA_BITS-1:0]  y;
      logic signed [ANGLE_BITS-1:0] z;
      logic signed [DATA_BITS-1:0]  yv;
      logic signed [ANGLE_BITS-1:0] pan;
      logic                         mode;
      logic                         degen;
      logic                         tilt_zero;
   } cordic_type;

   // atan(2^-i), 2^32 units per turn, truncated
   function automatic logic signed [ANGLE_BITS-1:0] atan_at(input logic [STEP_BITS-1:0] i);
      logic [31:0] a;
      case (i)
         5'd0:    a = 32'h20000000;
         5'd1:    a = 32'h12E4051D;
         5'd2:    a = 32'h09FB385B;
         5'd3:    a = 32'h051111D4;
         5'd4:    a = 32'h028B0D43;
         5'd5:    a = 32'h0145D7E1;
         5'd6:    a = 32'h00A2F61E;
         5'd7:    a = 32'h00517C55;
         5'd8:    a = 32'h0028BE53;
         5'd9:    a = 32'h00145F2E;
         5'd10:   a = 32'h000A2F98;
         5'd11:   a = 32'h000517CC;
         5'd12:   a = 32'h00028BE6;
         5'd13:   a = 32'h000145F3;
         5'd14:   a = 32'h0000A2F9;
         5'd15:   a = 32'h0000517C;
         5'd16:   a = 32'h000028BE;
         5'd17:   a = 32'h0000145F;
         5'd18:   a = 32'h00000A2F;
         5'd19:   a = 32'h00000517;
         5'd20:   a = 32'h0000028B;
         5'd21:   a = 32'h00000145;
         5'd22:   a = 32'h000000A2;
         5'd23:   a = 32'h00000051;
         default: a = 32'h0;
      endcase
      return $signed({{(ANGLE_BITS-32){1'b0}}, a});
   endfunction

endpackage

>>> hw/rtl/ptaa_prep.sv
// ----------------------------------------------------------------------------
// ptaa_prep
// Difference vector, then scaled CORDIC seeds and the gained -dy term.
// ----------------------------------------------------------------------------
module ptaa_prep (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic                                   req_valid,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_head_x,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_head_y,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_head_z,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_target_x,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_target_y,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_target_z,
   input  logic                                   req_mode,
   output logic                                   seed_valid,
   output ptaa_pkg::cordic_type                   seed
);
   localparam int DB = ptaa_pkg::DIFF_BITS;
   localparam int W  = ptaa_pkg::DATA_BITS;
   localparam int GS = ptaa_pkg::GUARD_SHIFT;
   localparam int PB = DB + 1 + ptaa_pkg::GAIN_BITS;

   logic                 a_v_ff, a_v_in;
   logic signed [DB-1:0] dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic                 mode_ff;
   logic                 b_v_ff;
   ptaa_pkg::cordic_type b_ff, b_in;
   logic [DB-1:0]        ax;
   logic signed [DB:0]   ndy;
   logic signed [PB-1:0] prod;

   // stage A: differences
   assign a_v_in = req_valid;
   assign dx_in  = DB'(req_target_x) - DB'(req_head_x);
   assign dy_in  = DB'(req_target_y) - DB'(req_head_y);
   assign dz_in  = DB'(req_target_z) - DB'(req_head_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (advance) begin
         a_v_ff <= a_v_in;
      end
      if (advance) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         dz_ff   <= dz_in;
         mode_ff <= req_mode;
      end
   end

   // stage B: seeds
   always_comb begin
      ax   = dx_ff[DB-1] ? DB'(-dx_ff) : DB'(dx_ff);
      ndy  = -(DB+1)'(dy_ff);
      prod = PB'(ndy) * PB'(ptaa_pkg::GAIN_Q16);
      b_in.x         = $signed({{(W-DB-GS){1'b0}}, ax, {GS{1'b0}}});
      b_in.y         = $signed({{(W-DB-GS){dz_ff[DB-1]}}, dz_ff, {GS{1'b0}}});
      b_in.z         = '0;
      b_in.yv        = $signed({{(W-PB-8){prod[PB-1]}}, prod, 8'b0});
      b_in.pan       = '0;
      b_in.mode      = mode_ff;
      b_in.degen     = (dx_ff == '0) && (dz_ff == '0);
      b_in.tilt_zero = (dx_ff == '0) && (dz_ff == '0) && (dy_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (advance) begin
         b_v_ff <= a_v_ff;
      end
      if (advance) begin
         b_ff <= b_in;
      end
   end

   assign seed_valid = b_v_ff;
   assign seed       = b_ff;
endmodule

>>> hw/rtl/ptaa_cordic_step.sv
// ----------------------------------------------------------------------------
// ptaa_cordic_step
// One registered vectoring CORDIC iteration; step index is tied off.
// ----------------------------------------------------------------------------
module ptaa_cordic_step (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic [ptaa_pkg::STEP_BITS-1:0]     step_idx,
   input  logic                               valid_in,
   input  ptaa_pkg::cordic_type               step_in,
   output logic                               valid_out,
   output ptaa_pkg::cordic_type               step_out
);
   localparam int W = ptaa_pkg::DATA_BITS;

   logic                 v_ff;
   ptaa_pkg::cordic_type d_ff, d_in;
   logic signed [W-1:0]  xs, ys;

   always_comb begin
      xs   = step_in.x >>> step_idx;
      ys   = step_in.y >>> step_idx;
      d_in = step_in;
      if (!step_in.y[W-1]) begin
         d_in.x = step_in.x + ys;
         d_in.y = step_in.y - xs;
         d_in.z = step_in.z + ptaa_pkg::atan_at(step_idx);
      end else begin
         d_in.x = step_in.x - ys;
         d_in.y = step_in.y + xs;
         d_in.z = step_in.z - ptaa_pkg::atan_at(step_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (advance) begin
         v_ff <= valid_in;
      end
      if (advance) begin
         d_ff <= d_in;
      end
   end

   assign valid_out = v_ff;
   assign step_out  = d_ff;
endmodule

>>> hw/rtl/ptaa_level.sv
// ----------------------------------------------------------------------------
// ptaa_level
// Angle to Q0.16 level mapping, clamping and the result register.
// ----------------------------------------------------------------------------
`include "pan_tilt_aim_angles_unit_assert.svh"

module ptaa_level (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 valid_in,
   input  ptaa_pkg::cordic_type lvl_in,
   output logic                 rsp_valid,
   output logic [15:0]          rsp_pan_level,
   output logic [15:0]          rsp_tilt_level,
   output logic                 rsp_degenerate
);
   localparam int AB = ptaa_pkg::ANGLE_BITS;
   localparam int VB = 19;
   localparam logic [17:0] RECIP3 = 18'd174763;   // ceil(2^19 / 3)

   logic signed [AB-1:0] pan_s, tilt_s, pnum, tnum;
   logic [15:0]          pan_in;
   logic [VB-1:0]        v_in;
   logic                 tpos_in;

   logic                 l1_v_ff;
   logic [15:0]          pan_ff;
   logic [VB-1:0]        v_ff;
   logic                 tpos_ff, degen_ff;

   logic [VB+17:0]       prod;
   logic [17:0]          q;
   logic [15:0]          tilt_in;

   logic                 rsp_valid_ff;
   logic [15:0]          rsp_pan_level_ff, rsp_tilt_level_ff;
   logic                 rsp_degenerate_ff;

   // stage 1: pan level, tilt numerator / 8192
   always_comb begin
      pan_s  = lvl_in.mode ? lvl_in.pan : -lvl_in.pan;
      pnum   = pan_s + AB'(64'sd1073758208);          // 2^30 + 2^14
      if (lvl_in.degen)
         pan_in = 16'h8000;
      else if (pnum[AB-1])
         pan_in = 16'h0000;
      else if (pnum[AB-2:31] != '0)
         pan_in = 16'hFFFF;
      else
         pan_in = pnum[30:15];
      tilt_s  = lvl_in.tilt_zero ? '0 : lvl_in.z;
      tnum    = AB'(64'sd536870912) - tilt_s;          // 2^29 - tilt
      tpos_in = !tnum[AB-1] && (tnum != '0);
      v_in    = VB'((tnum + AB'(64'sd12288)) >>> 13);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_v_ff <= 1'b0;
      end else if (advance) begin
         l1_v_ff <= valid_in;
      end
      if (advance) begin
         pan_ff   <= pan_in;
         v_ff     <= v_in;
         tpos_ff  <= tpos_in;
         degen_ff <= lvl_in.degen;
      end
   end

   // stage 2: divide by 3 through the reciprocal, clamp
   always_comb begin
      prod = (VB+18)'(v_ff) * (VB+18)'(RECIP3);
      q    = prod[VB+17:19];
      if (!tpos_ff)
         tilt_in = 16'h0000;
      else if (q[17:16] != 2'b00)
         tilt_in = 16'hFFFF;
      else
         tilt_in = q[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= l1_v_ff;
      end
      if (advance) begin
         rsp_pan_level_ff  <= pan_ff;
         rsp_tilt_level_ff <= tilt_in;
         rsp_degenerate_ff <= degen_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pan_level  = rsp_pan_level_ff;
   assign rsp_tilt_level = rsp_tilt_level_ff;
   assign rsp_degenerate = rsp_degenerate_ff;

   `PTAA_ASSERT_IMPLY(a_degen_center, clock, reset, rsp_valid_ff && rsp_degenerate_ff, rsp_pan_level_ff == 16'h8000)
   `PTAA_ASSERT_NEXT(a_hold_when_blocked, clock, reset, rsp_valid_ff && !advance, rsp_valid_ff)
   `PTAA_ASSERT_IMPLY(a_valid_source, clock, reset, !$past(reset) && $rose(rsp_valid_ff), $past(l1_v_ff && advance))
endmodule

>>> hw/rtl/pan_tilt_aim_angles_unit.sv
// ----------------------------------------------------------------------------
// pan_tilt_aim_angles_unit
// Pan and tilt levels for a moving head aimed from its position at a target.
// ----------------------------------------------------------------------------
// Takes one beat per clock while no result beat is stalled and returns one
// result beat per input beat, in order. A beat passes the difference and
// seed registers, the two chained 16-iteration vectoring CORDICs (one
// register per iteration) and the level and result registers; the pipeline
// runs as one unit and halts as a whole while a result beat is stalled.
// Pan = atan2(dz,|dx|) (negated for mode 0) mapped -90..+90 to 0..1;
// tilt = atan2(-dy, horizontal length) mapped +45..-90 to 0..1; both Q0.16,
// clamped. With dx = dz = 0 the degenerate flag is set and pan reads 0.5;
// if dy is also zero tilt reads as level for 0 degrees.
// ----------------------------------------------------------------------------
module pan_tilt_aim_angles_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_head_x,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_head_y,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_head_z,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_target_x,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_target_y,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_target_z,
   input  logic                                   req_mode,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [15:0]                            rsp_pan_level,
   output logic [15:0]                            rsp_tilt_level,
   output logic                                   rsp_degenerate
);
   localparam int N = ptaa_pkg::ANGLE_STEPS;

   logic                 advance;
   logic                 chain_v [0:2*N];
   ptaa_pkg::cordic_type chain_d [0:2*N];
   ptaa_pkg::cordic_type tilt_seed;

   // whole pipe moves unless a finished beat is held at the output
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   ptaa_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .req_valid    (req_valid),
      .req_head_x   (req_head_x),
      .req_head_y   (req_head_y),
      .req_head_z   (req_head_z),
      .req_target_x (req_target_x),
      .req_target_y (req_target_y),
      .req_target_z (req_target_z),
      .req_mode     (req_mode),
      .seed_valid   (chain_v[0]),
      .seed         (chain_d[0])
   );

   // second CORDIC: x = gained horizontal length, y = gained -dy
   always_comb begin
      tilt_seed     = chain_d[N];
      tilt_seed.pan = chain_d[N].z;
      tilt_seed.y   = chain_d[N].yv;
      tilt_seed.z   = '0;
   end

   for (genvar i = 0; i < 2*N; i++) begin : g_step
      ptaa_pkg::cordic_type stage_in;
      if (i == N) begin : g_tilt_seed
         assign stage_in = tilt_seed;
      end else begin : g_chain
         assign stage_in = chain_d[i];
      end
      ptaa_cordic_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .step_idx  (ptaa_pkg::STEP_BITS'(i % N)),
         .valid_in  (chain_v[i]),
         .step_in   (stage_in),
         .valid_out (chain_v[i+1]),
         .step_out  (chain_d[i+1])
      );
   end

   ptaa_level u_level (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .valid_in       (chain_v[2*N]),
      .lvl_in         (chain_d[2*N]),
      .rsp_valid      (rsp_valid),
      .rsp_pan_level  (rsp_pan_level),
      .rsp_tilt_level (rsp_tilt_level),
      .rsp_degenerate (rsp_degenerate)
   );
endmodule

>>> bench/pan_tilt_aim_angles_unit_check.sv
// ----------------------------------------------------------------------------
// Aim level checker
// Watches both channels of the pan/tilt aim unit, predicts the pan and tilt
// levels of every accepted request beat and compares them in order.
// ----------------------------------------------------------------------------
module pan_tilt_aim_angles_unit_check (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_head_x,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_head_y,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_head_z,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_target_x,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_target_y,
   input  logic signed [ptaa_pkg::COORD_BITS-1:0] req_target_z,
   input  logic                                   req_mode,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic [15:0]                            rsp_pan_level,
   input  logic [15:0]                            rsp_tilt_level,
   input  logic                                   rsp_degenerate,
   output int                                     fail_count,
   output int                                     aims_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] pan_level;
      logic [15:0] tilt_level;
      logic        degenerate;
   } aim_levels_type;

   localparam longint ATAN_TURN32 [24] = '{
      64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
      64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
      64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};

   aim_levels_type expected_aims[$];

   // vectoring rotation: angle of (x, y); x leaves holding the scaled length
   function automatic longint vector_angle(inout longint x, input longint y);
      longint z, xs, ys;
      z = 0;
      for (int i = 0; i < ptaa_pkg::ANGLE_STEPS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z += ATAN_TURN32[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z -= ATAN_TURN32[i];
         end
      end
      return z;
   endfunction

   function automatic longint clamp_level(input longint v);
      return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
   endfunction

   function automatic aim_levels_type aim_levels(
      input logic signed [15:0] hx, hy, hz, tx, ty, tz, input logic keep);
      aim_levels_type r;
      longint dx, dy, dz, h, ax, pan, tilt, num, lx;
      dx = longint'(tx) - longint'(hx);
      dy = longint'(ty) - longint'(hy);
      dz = longint'(tz) - longint'(hz);
      h = 0;
      if (dx == 0 && dz == 0) begin
         r.degenerate = 1'b1;
         r.pan_level  = 16'd32768;
      end else begin
         ax = (dx < 0) ? -dx : dx;
         h = ax * (64'sd1 <<< 24);
         pan = vector_angle(h, dz * (64'sd1 <<< 24));
         if (!keep) pan = -pan;
         r.degenerate = 1'b0;
         r.pan_level  = 16'(clamp_level((pan + (64'sd1 <<< 30) + (64'sd1 <<< 14)) / 32768));
      end
      if (r.degenerate && dy == 0) begin
         tilt = 0;
      end else begin
         lx = h;
         tilt = vector_angle(lx, (-dy) * 107922 * 256);
      end
      num = (64'sd1 <<< 29) - tilt;
      r.tilt_level = (num <= 0) ? 16'd0 : 16'(clamp_level((num + 12288) / 24576));
      return r;
   endfunction

   always @(posedge clock) begin
      aim_levels_type want;
      if (reset) begin
         fail_count = 0;
         expected_aims.delete();
      end else begin
         if (req_valid && !req_stall)
            expected_aims.push_back(aim_levels(req_head_x, req_head_y, req_head_z,
               req_target_x, req_target_y, req_target_z, req_mode));
         if (rsp_valid && !rsp_stall) begin
            if (expected_aims.size() == 0) begin
               $display("%0t: unexpected result beat pan=%0d tilt=%0d degen=%0b", $time,
                  rsp_pan_level, rsp_tilt_level, rsp_degenerate);
               fail_count++;
            end else begin
               want = expected_aims.pop_front();
               if (rsp_pan_level !== want.pan_level) begin
                  $display("%0t: pan_level expected %0d actual %0d", $time,
                     want.pan_level, rsp_pan_level);
                  fail_count++;
               end
               if (rsp_tilt_level !== want.tilt_level) begin
                  $display("%0t: tilt_level expected %0d actual %0d", $time,
                     want.tilt_level, rsp_tilt_level);
                  fail_count++;
               end
               if (rsp_degenerate !== want.degenerate) begin
                  $display("%0t: degenerate expected %0b actual %0b", $time,
                     want.degenerate, rsp_degenerate);
                  fail_count++;
               end
            end
         end
      end
      aims_pending <= expected_aims.size();
   end

endmodule

>>> bench/pan_tilt_aim_angles_unit_test.sv
// ----------------------------------------------------------------------------
// Pan/tilt aim unit test
// Drives fixture and target beats with random gaps and result back-pressure;
// the checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module pan_tilt_aim_angles_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_AIMS = 680;
   localparam int DRAIN_CYCLES = 60;   // idle clocks run after the checker's queue is empty

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, req_mode;
   logic signed [15:0] req_head_x, req_head_y, req_head_z;
   logic signed [15:0] req_target_x, req_target_y, req_target_z;
   logic [15:0] rsp_pan_level, rsp_tilt_level;
   logic rsp_degenerate;
   int fail_count, aims_pending;
   bit  sender_busy_run;    // no gaps on the request side
   bit  receiver_busy_run;  // no stalls on the result side

   pan_tilt_aim_angles_unit DUT (.*);
   pan_tilt_aim_angles_unit_check checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // send one aim beat after a random gap; valid held until accepted
   task automatic send_aim(input logic signed [15:0] hx, hy, hz, tx, ty, tz,
                           input logic m);
      int gap;
      gap = sender_busy_run ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_head_x   <= hx;
      req_head_y   <= hy;
      req_head_z   <= hz;
      req_target_x <= tx;
      req_target_y <= ty;
      req_target_z <= tz;
      req_mode     <= m;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // result side: stall a random number of cycles, then take one beat
   initial begin
      int n;
      rsp_stall <= 1'b1;
      @(negedge reset);
      forever begin
         n = receiver_busy_run ? 0 : $urandom_range(0, 8);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      logic signed [15:0] hx, hy, hz;
      int span;
      reset = 1'b1;
      req_valid <= 1'b0;
      {req_head_x, req_head_y, req_head_z} <= '0;
      {req_target_x, req_target_y, req_target_z} <= '0;
      req_mode <= 1'b0;
      sender_busy_run = 0;
      receiver_busy_run = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, degenerate aims, full-scale pan and tilt
      send_aim(0, 0, 0, 0, 0, 0, 0);                            // zero vector
      send_aim(100, 100, 100, 100, 100, 100, 1);
      send_aim(0, 0, 0, 0, 16'sd256, 0, 1);                     // straight up
      send_aim(0, 0, 0, 0, -16'sd256, 0, 0);                    // straight down
      send_aim(0, -32768, 0, 0, 32767, 0, 1);
      send_aim(0, 32767, 0, 0, -32768, 0, 0);
      send_aim(-32768, 0, 0, 32767, 0, 0, 1);                   // pan zero
      send_aim(32767, 0, 0, -32768, 0, 0, 0);
      send_aim(0, 0, -32768, 0, 0, 32767, 1);                   // pan +90
      send_aim(0, 0, -32768, 0, 0, 32767, 0);                   // pan -90
      send_aim(0, 0, 32767, 0, 0, -32768, 1);
      send_aim(0, 0, 32767, 0, 0, -32768, 0);
      send_aim(-32768, 32767, -32768, 32767, -32768, 32767, 1);
      send_aim(32767, -32768, 32767, -32768, 32767, -32768, 0);
      send_aim(0, 0, 0, 1, 0, 1, 1);
      send_aim(0, 0, 0, 1, -1, -1, 0);
      send_aim(0, 0, 0, 256, 256, 0, 1);                        // 45 deg up
      send_aim(0, 0, 0, 256, -256, 0, 0);                       // 45 deg down
      send_aim(-1, -1, -1, -1, -1, -1, 1);
      send_aim(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 0);

      for (int i = 0; i < RANDOM_AIMS; i++) begin
         if (i % 100 == 0) begin
            sender_busy_run = ($urandom_range(0, 3) == 0);
            receiver_busy_run = ($urandom_range(0, 3) == 0);
         end
         hx = 16'($urandom); hy = 16'($urandom); hz = 16'($urandom);
         case ($urandom_range(0, 4))
            0: send_aim(hx, hy, hz, 16'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom));
            1: begin   // nearby targets, small differences
               span = $urandom_range(1, 1024);
               send_aim(hx, hy, hz,
                  16'(hx + $signed($urandom_range(0, 2 * span)) - span),
                  16'(hy + $signed($urandom_range(0, 2 * span)) - span),
                  16'(hz + $signed($urandom_range(0, 2 * span)) - span), 1'($urandom));
            end
            2: send_aim(hx, hy, hz, hx, 16'($urandom), hz, 1'($urandom));  // vertical only
            3: send_aim(hx, hy, hz,                                // level aims, often on an axis
                  ($urandom_range(0, 1) ? hx : 16'($urandom)), hy,
                  ($urandom_range(0, 1) ? hz : 16'($urandom)), 1'($urandom));
            default: send_aim(hx, hy, hz, 16'($urandom), hy, 16'($urandom),
                  1'($urandom));
         endcase
      end
      req_valid <= 1'b0;
      receiver_busy_run = 0;

      while (aims_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // generous cap: ~700 beats at worst-case gaps and stalls is well under this
   initial begin
      #2ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/ptaa_pkg.sv
hw/rtl/ptaa_prep.sv
hw/rtl/ptaa_cordic_step.sv
hw/rtl/ptaa_level.sv
hw/rtl/pan_tilt_aim_angles_unit.sv
bench/pan_tilt_aim_angles_unit_check.sv
bench/pan_tilt_aim_angles_unit_test.sv
